// ----- design/pse_pkg.sv -----
// Package for the postfix integer stack evaluator.
// Holds the request and result structs, the request, operator and status
// codes and the sequencer states. It depends on nothing else.
package pse_pkg;

  // One input item.
  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [63:0] operand;
    logic        [2:0]  op;
  } pse_req_t;

  // One result item.
  typedef struct packed {
    logic signed [63:0] value;
    logic        [2:0]  status;
    logic               done_res;
  } pse_res_t;

  // Request types. The last one only reports the state.
  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_OP   = 2'd1,
    REQ_END  = 2'd2,
    REQ_NOP  = 2'd3
  } req_e;

  // Operators.
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_AND = 3'd5,
    OP_OR  = 3'd6,
    OP_XOR = 3'd7
  } op_e;

  // Status codes.
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_UNDERFLOW = 3'd1,
    STAT_OVERFLOW  = 3'd2,
    STAT_DIVZERO   = 3'd3,
    STAT_BADDEPTH  = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_WB
  } state_e;

endpackage

// ----- design/postfix_int_stack_evaluator_unit.sv -----
// Top level of the postfix integer stack evaluator.
// The operand stack lives in a synchronous memory; uses pse_pkg.
//
// Usage: a request transfer happens at a rising edge with start high and busy
// low. Every request produces exactly one result, shown on res_o for one cycle
// with res_valid_o high; the receiver cannot stall it.
// Push, end and unknown requests, and operators with fewer than two operands,
// are answered in the next cycle and busy stays low, so such requests may
// follow every cycle.
// An operator request on two or more operands raises busy while the
// sequencer works:
//   add, sub, and, or, xor and divide by zero: read, write back,
//   mul: read, multiply (three 32x32 partial products on one shared
//   multiplier), write back; div and mod: read, one quotient bit per cycle
//   in a radix-2 restoring divider, sign fix and write back.
// The result strobe follows the last busy cycle; the next request may be
// taken in that same cycle.
// The top of the stack is kept in a register, so an operator needs only one
// memory read (the entry below the top) and one write back.
// Reset clears the depth, the sticky error and the sequencer at once; the
// memory itself is not cleared, since only entries below the depth are read.
module postfix_int_stack_evaluator_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pse_pkg::pse_req_t req_i,
  output pse_pkg::pse_res_t res_o,
  output logic              res_valid_o
);
  import pse_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // Control state.
  state_e        state_q, state_d;
  logic [DW-1:0] depth_q, depth_d;
  status_e       err_q, err_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          res_valid_q, res_valid_d;

  // Datapath registers.
  logic [63:0] tos_q, tos_d;
  op_e         op_q, op_d;
  logic [63:0] a_q, a_d;
  logic [63:0] b_q, b_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] acc_q, acc_d;
  logic        neg_q_q, neg_q_d;
  logic        neg_r_q, neg_r_d;
  pse_res_t    res_q, res_d;

  // Memory port.
  logic [63:0] stack_mem [STACK_DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata, mem_rdata_q;

  // Helpers.
  logic [DW-1:0] depth_m2;
  logic          depth_full, depth_lt2, depth_zero;
  logic [63:0]   rd_a;
  logic          b_zero;
  logic [31:0]   mul_x, mul_y;
  logic [64:0]   rem_sh, rem_diff;

  assign depth_m2   = depth_q - DW'(2);
  assign depth_full = (depth_q >= DW'(STACK_DEPTH));
  assign depth_lt2  = (depth_q < DW'(2));
  assign depth_zero = (depth_q == '0);
  assign rd_a       = mem_rdata_q;
  assign b_zero     = (tos_q == 64'd0);

  // Stack memory: one write and one registered read per cycle. A write back
  // always lands before the next read is issued, so no forwarding.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= stack_mem[mem_raddr];
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && (req_e'(req_i.req_type) == REQ_OP) && !depth_lt2) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        case (op_q)
          OP_MUL: state_d = ST_MUL;
          OP_DIV, OP_MOD: state_d = b_zero ? ST_WB : ST_DIV;
          default: state_d = ST_WB;
        endcase
      end
      ST_MUL: begin
        if (cnt_q == 6'd3) begin
          state_d = ST_WB;
        end
      end
      ST_DIV: begin
        if (cnt_q == 6'd63) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: state_d = ST_WB;
      ST_WB: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: busy flag and memory controls.
  always_comb begin
    busy      = (state_q != ST_IDLE);
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = depth_q[AW-1:0];
    mem_raddr = depth_m2[AW-1:0];
    mem_wdata = req_i.operand;
    unique case (state_q)
      ST_IDLE: begin
        if (start && (req_e'(req_i.req_type) == REQ_PUSH) && !depth_full) begin
          mem_we = 1'b1;
        end
        if (start && (req_e'(req_i.req_type) == REQ_OP) && !depth_lt2) begin
          mem_re = 1'b1;
        end
      end
      ST_WB: begin
        mem_we    = 1'b1;
        mem_waddr = depth_m2[AW-1:0];
        mem_wdata = acc_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Multiplier operand selection: low x low, low x high, high x low.
  always_comb begin
    case (cnt_q[1:0])
      2'd0: begin
        mul_x = a_q[31:0];
        mul_y = b_q[31:0];
      end
      2'd1: begin
        mul_x = a_q[31:0];
        mul_y = b_q[63:32];
      end
      default: begin
        mul_x = a_q[63:32];
        mul_y = b_q[31:0];
      end
    endcase
  end

  // One restoring division step: a_q shifts the dividend out and the
  // quotient in.
  assign rem_sh   = {rem_q[63:0], a_q[63]};
  assign rem_diff = rem_sh - {1'b0, b_q};

  // Datapath next values.
  always_comb begin
    depth_d     = depth_q;
    err_d       = err_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    tos_d       = tos_q;
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    rem_d       = rem_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    neg_q_d     = neg_q_q;
    neg_r_d     = neg_r_q;
    res_d       = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          res_d.done_res = 1'b0;
          case (req_e'(req_i.req_type))
            REQ_PUSH: begin
              res_valid_d = 1'b1;
              if (depth_full) begin
                if (err_q == STAT_OK) begin
                  err_d = STAT_OVERFLOW;
                end
                res_d.value = tos_q;
              end else begin
                depth_d     = depth_q + DW'(1);
                tos_d       = req_i.operand;
                res_d.value = req_i.operand;
              end
              res_d.status = (err_q == STAT_OK && depth_full) ? STAT_OVERFLOW : err_q;
            end
            REQ_OP: begin
              op_d = op_e'(req_i.op);
              if (depth_lt2) begin
                res_valid_d = 1'b1;
                if (err_q == STAT_OK) begin
                  err_d = STAT_UNDERFLOW;
                end
                res_d.value  = depth_zero ? 64'd0 : tos_q;
                res_d.status = (err_q == STAT_OK) ? STAT_UNDERFLOW : err_q;
              end
            end
            REQ_END: begin
              res_valid_d    = 1'b1;
              res_d.done_res = 1'b1;
              if (err_q != STAT_OK) begin
                res_d.status = err_q;
                res_d.value  = 64'd0;
              end else if (depth_q != DW'(1)) begin
                res_d.status = STAT_BADDEPTH;
                res_d.value  = 64'd0;
              end else begin
                res_d.status = STAT_OK;
                res_d.value  = tos_q;
              end
              depth_d = '0;
              err_d   = STAT_OK;
            end
            default: begin
              res_valid_d  = 1'b1;
              res_d.value  = depth_zero ? 64'd0 : tos_q;
              res_d.status = err_q;
            end
          endcase
        end
      end
      ST_READ: begin
        // The entry below the top is now in the read register.
        cnt_d = '0;
        case (op_q)
          OP_ADD: acc_d = rd_a + tos_q;
          OP_SUB: acc_d = rd_a - tos_q;
          OP_AND: acc_d = rd_a & tos_q;
          OP_OR:  acc_d = rd_a | tos_q;
          OP_XOR: acc_d = rd_a ^ tos_q;
          OP_MUL: begin
            a_d = rd_a;
            b_d = tos_q;
          end
          default: begin
            if (b_zero) begin
              acc_d = 64'd0;
              if (err_q == STAT_OK) begin
                err_d = STAT_DIVZERO;
              end
            end else begin
              a_d     = rd_a[63] ? (64'd0 - rd_a) : rd_a;
              b_d     = tos_q[63] ? (64'd0 - tos_q) : tos_q;
              rem_d   = '0;
              neg_q_d = rd_a[63] ^ tos_q[63];
              neg_r_d = rd_a[63];
            end
          end
        endcase
      end
      ST_MUL: begin
        // Product of this step is registered; the previous one is summed.
        prod_d = 64'(mul_x) * 64'(mul_y);
        cnt_d  = cnt_q + 6'd1;
        case (cnt_q[1:0])
          2'd0: acc_d = acc_q;
          2'd1: acc_d = prod_q;
          default: acc_d = acc_q + {prod_q[31:0], 32'd0};
        endcase
      end
      ST_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (!rem_diff[64]) begin
          rem_d = rem_diff;
          a_d   = {a_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          a_d   = {a_q[62:0], 1'b0};
        end
      end
      ST_FIX: begin
        // Quotient takes the sign of the operands, remainder of the dividend.
        if (op_q == OP_MOD) begin
          acc_d = neg_r_q ? (64'd0 - rem_q[63:0]) : rem_q[63:0];
        end else begin
          acc_d = neg_q_q ? (64'd0 - a_q) : a_q;
        end
      end
      ST_WB: begin
        depth_d        = depth_q - DW'(1);
        tos_d          = acc_q;
        res_valid_d    = 1'b1;
        res_d.value    = acc_q;
        res_d.status   = err_q;
        res_d.done_res = 1'b0;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= '0;
      err_q       <= STAT_OK;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      err_q       <= err_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    tos_q   <= tos_d;
    op_q    <= op_d;
    a_q     <= a_d;
    b_q     <= b_d;
    rem_q   <= rem_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    neg_q_q <= neg_q_d;
    neg_r_q <= neg_r_d;
    res_q   <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

// ----- design/pse_checker.sv -----
// Port-level checker for the postfix integer stack evaluator.
// Uses pse_pkg and is bound to postfix_int_stack_evaluator_unit below.
module pse_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input pse_pkg::pse_req_t req_i,
  input pse_pkg::pse_res_t res_o,
  input logic              res_valid_o
);
  import pse_pkg::*;

  // A result is only shown once the sequencer has finished.
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result strobe while busy");

  // Push, end and unknown requests answer in the next cycle.
  a_short_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.req_type != REQ_OP)) |=> res_valid_o)
    else $error("missing one-cycle result");

  // Busy only rises after an operator request transfer.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (req_i.req_type == REQ_OP)))
    else $error("busy without operator request");

  // A failed end reports a zero value.
  a_end_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.done_res && (res_o.status != STAT_OK)) |->
      (res_o.value == 64'd0))
    else $error("nonzero value on failed end");

  // Bad final depth is only ever reported for an end request.
  a_baddepth_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.done_res) |-> (res_o.status != STAT_BADDEPTH))
    else $error("bad depth status outside end");

endmodule

bind postfix_int_stack_evaluator_unit pse_checker u_pse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .req_i      (req_i),
  .res_o      (res_o),
  .res_valid_o(res_valid_o)
);

// ----- bench/pse_eval_checker.sv -----
// Result checker for the postfix integer stack evaluator bench.
// Predicts every result from the request transfers it observes and compares
// them in order with the result transfers; uses pse_pkg.
module pse_eval_checker #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  pse_pkg::pse_req_t req_i,
  input  pse_pkg::pse_res_t res_i,
  input  logic              res_valid_i,
  output int                mismatch_cnt_o,
  output int                pending_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

  // Shadow copy of the evaluator state.
  logic [63:0] shadow_stack [STACK_DEPTH];
  int          shadow_depth;
  status_e     shadow_error;

  // Results still owed by the block, oldest first.
  pse_res_t    owed_results [$];
  int          n_fail = 0;

  // Only the first error since the last end token is kept.
  function automatic void latch_error(status_e code);
    if (shadow_error == STAT_OK) begin
      shadow_error = code;
    end
  endfunction

  function automatic logic [63:0] shadow_top();
    if (shadow_depth == 0) begin
      return '0;
    end
    return shadow_stack[shadow_depth - 1];
  endfunction

  // Binary operator on the two topmost operands; a sits below b.
  function automatic logic [63:0] combine(logic [2:0] opc, logic [63:0] a, logic [63:0] b);
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    sa = a;
    sb = b;
    case (opc)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_AND: return a & b;
      OP_OR:  return a | b;
      OP_XOR: return a ^ b;
      default: ;
    endcase
    // Division and remainder: zero divisor and the one overflowing quotient.
    if (b == '0) begin
      latch_error(STAT_DIVZERO);
      return '0;
    end
    if (a == INT64_MIN && b == '1) begin
      return (opc == OP_DIV) ? a : '0;
    end
    return (opc == OP_DIV) ? 64'(sa / sb) : 64'(sa % sb);
  endfunction

  // Applies one request to the shadow state and returns its result.
  function automatic pse_res_t eval_token(pse_req_t rq);
    pse_res_t r;
    logic [63:0] lhs;
    logic [63:0] rhs;
    status_e st;
    r = '0;
    case (rq.req_type)
      REQ_PUSH: begin
        if (shadow_depth >= STACK_DEPTH) begin
          latch_error(STAT_OVERFLOW);
        end else begin
          shadow_stack[shadow_depth] = rq.operand;
          shadow_depth++;
        end
        r.value  = shadow_top();
        r.status = shadow_error;
      end
      REQ_OP: begin
        if (shadow_depth < 2) begin
          latch_error(STAT_UNDERFLOW);
        end else begin
          lhs = shadow_stack[shadow_depth - 2];
          rhs = shadow_stack[shadow_depth - 1];
          shadow_depth -= 2;
          shadow_stack[shadow_depth] = combine(rq.op, lhs, rhs);
          shadow_depth++;
        end
        r.value  = shadow_top();
        r.status = shadow_error;
      end
      REQ_END: begin
        if (shadow_error != STAT_OK) begin
          st = shadow_error;
        end else if (shadow_depth != 1) begin
          st = STAT_BADDEPTH;
        end else begin
          st = STAT_OK;
        end
        r.value      = (st == STAT_OK) ? shadow_stack[0] : '0;
        r.status     = st;
        r.done_res   = 1'b1;
        shadow_depth = 0;
        shadow_error = STAT_OK;
      end
      default: begin
        // Unknown request type: reports the state and changes nothing.
        r.value  = shadow_top();
        r.status = shadow_error;
      end
    endcase
    return r;
  endfunction

  // Compare result transfers first, since a request never answers in its own cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    pse_res_t want;
    if (!rst_ni) begin
      shadow_depth = 0;
      shadow_error = STAT_OK;
      owed_results.delete();
    end else begin
      if (res_valid_i) begin
        if (owed_results.size() == 0) begin
          $error("result transfer with no request outstanding: value %h status %0d",
                 res_i.value, res_i.status);
          n_fail++;
        end else begin
          want = owed_results.pop_front();
          if (res_i.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, res_i.value);
            n_fail++;
          end
          if (res_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_i.status);
            n_fail++;
          end
          if (res_i.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, res_i.done_res);
            n_fail++;
          end
        end
      end
      if (start_i && !busy_i) begin
        owed_results.push_back(eval_token(req_i));
      end
    end
    mismatch_cnt_o <= n_fail;
    pending_cnt_o  <= owed_results.size();
  end

endmodule

// ----- bench/postfix_int_stack_evaluator_unit_tb.sv -----
// Top of the bench for the postfix integer stack evaluator.
// Drives directed and random token streams into the unit; checking is done
// by pse_eval_checker. Depends on pse_pkg and the design top.
module postfix_int_stack_evaluator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  localparam int          STACK_DEPTH    = 32;
  localparam int          TOKEN_TARGET   = 900;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [63:0] INT64_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] INT64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  pse_req_t req_i;
  pse_res_t res_o;
  logic     res_valid_o;

  int mismatch_cnt;
  int pending_cnt;
  int stall_cycles = 0;
  int n_sent = 0;
  int burst_left = 0;
  bit start_on = 1'b0;

  postfix_int_stack_evaluator_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  pse_eval_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req_i),
    .res_i         (res_o),
    .res_valid_i   (res_valid_o),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_cnt_o (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Ends the run when neither side has made a transfer for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Operand values weighted toward zero, minus one, the extremes and small numbers.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return INT64_MIN;
      3:       return INT64_MAX;
      4, 5:    return longint'(int'($urandom_range(0, 40)) - 20);
      6:       return {32'h0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic pse_req_t mk_req(logic [1:0] kind, logic [63:0] val, logic [2:0] opc);
    pse_req_t r;
    r.req_type = kind;
    r.operand  = val;
    r.op       = opc;
    return r;
  endfunction

  task automatic lower_start();
    if (start_on) begin
      start    <= 1'b0;
      start_on = 1'b0;
    end
  endtask

  // One request transfer, followed by a random gap at the end of each burst.
  task automatic send_item(pse_req_t item);
    int gap;
    start    <= 1'b1;
    start_on = 1'b1;
    req_i    <= item;
    do @(posedge clk_i); while (busy);
    if (item.req_type != REQ_NOP) begin
      n_sent++;
    end
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        lower_start();
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic push_val(logic [63:0] val);
    send_item(mk_req(REQ_PUSH, val, 3'($urandom)));
  endtask

  task automatic apply_op(op_e opc);
    send_item(mk_req(REQ_OP, {$urandom, $urandom}, opc));
  endtask

  task automatic end_expr();
    send_item(mk_req(REQ_END, {$urandom, $urandom}, 3'($urandom)));
  endtask

  // Holds requests back until every outstanding result has come out.
  task automatic drain_results();
    lower_start();
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  // Well-formed postfix body; a deep one pushes all operands first, at most filling the stack.
  task automatic build_expr(bit deep);
    int n_ops;
    int pushes_left;
    int depth_now;
    n_ops = deep ? $urandom_range(8, STACK_DEPTH - 1) : $urandom_range(0, 6);
    pushes_left = n_ops + 1;
    depth_now = 0;
    while (pushes_left > 0 || depth_now > 1) begin
      if (pushes_left > 0 && (deep || depth_now < 2 || $urandom_range(0, 1) == 1)) begin
        push_val(rand_word());
        pushes_left--;
        depth_now++;
      end else begin
        apply_op(op_e'($urandom_range(0, 7)));
        depth_now--;
      end
    end
  endtask

  initial begin
    int mix;
    start  <= 1'b0;
    req_i  <= '0;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Underflow on an empty stack, end with an error, end on an empty stack.
    apply_op(OP_ADD);
    end_expr();
    end_expr();
    // Wrapping add, most negative value divided by minus one and its remainder.
    push_val(INT64_MAX);
    push_val(64'd1);
    apply_op(OP_ADD);
    push_val('1);
    apply_op(OP_DIV);
    push_val('1);
    apply_op(OP_MOD);
    // Remainder takes the sign of the dividend.
    push_val(-64'sd7);
    push_val(64'd2);
    apply_op(OP_MOD);
    apply_op(OP_MUL);
    // Division by zero, then evaluation goes on with the error kept.
    push_val('0);
    apply_op(OP_DIV);
    push_val(64'hF0F0_F0F0_F0F0_F0F0);
    apply_op(OP_AND);
    push_val(64'h0FF0_0FF0_0FF0_0FF0);
    apply_op(OP_OR);
    push_val(64'h5555_AAAA_5555_AAAA);
    apply_op(OP_XOR);
    push_val(64'd5);
    apply_op(OP_SUB);
    // Unknown request type with every other bit set.
    send_item(mk_req(REQ_NOP, '1, 3'b111));
    end_expr();
    drain_results();

    // Random part: mostly valid expressions, some noise, broken ones and overflows.
    while (n_sent < TOKEN_TARGET) begin
      mix = $urandom_range(0, 19);
      if (mix < 15) begin
        build_expr(mix < 2);
        end_expr();
      end else if (mix < 17) begin
        repeat ($urandom_range(1, 8)) begin
          send_item(mk_req(2'($urandom_range(0, 3)), rand_word(), 3'($urandom)));
        end
      end else if (mix < 19) begin
        build_expr(1'b0);
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(0, 1) == 1) begin
            push_val(rand_word());
          end else begin
            apply_op(op_e'($urandom_range(0, 7)));
          end
        end
        end_expr();
      end else begin
        repeat (STACK_DEPTH + $urandom_range(1, 4)) push_val(rand_word());
        repeat ($urandom_range(0, 3)) apply_op(op_e'($urandom_range(0, 7)));
        end_expr();
      end
      if ($urandom_range(0, 19) == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (80) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
